### src/kmq_pkg.sv
`default_nettype none

package kmq_pkg;

   // Operation codes of an input beat.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_EDIT   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_EXEC   = 2'd3
   } op_type;

   // Status codes of a result beat.
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_DUP      = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   // One input beat.
   typedef struct packed {
      op_type      op;
      logic [15:0] user_id;
      logic [15:0] task_id;
      logic [31:0] priority_req;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [15:0] owner_out;
      status_type  status;
   } rsp_type;

   // One slot of the task memory.
   typedef struct packed {
      logic        used;
      logic [15:0] task_id;
      logic [15:0] owner;
      logic [31:0] prio;
   } slot_type;

   // Phase strobes from the controller.
   typedef struct packed {
      logic busy;
      logic clearing;
      logic accept;
      logic scan_rd;
      logic commit;
   } ctrl_type;

   // Summary gathered by one pass over the memory.
   typedef struct packed {
      logic        found;
      logic [15:0] found_owner;
      logic        free_found;
      logic        top_found;
      logic [15:0] top_owner;
   } scan_type;

endpackage

`default_nettype wire

### src/keyed_max_priority_task_queue_core.sv
// The result strobe is registered from the commit state; after the accepting edge the
// controller runs the scan, drain and commit states. Busy covers one full read pass over
// the slot memory, a drain state for the last read data and a write-back (commit) state,
// and the next request is taken in the idle state that follows. Results cannot be stalled.
// Reset: synchronous, active high; afterwards a clearing pass over every slot
// keeps busy high while every slot is marked free.
`default_nettype none

module keyed_max_priority_task_queue_core
   import kmq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);

   ctrl_type      ctl;
   logic [AW-1:0] addr;
   slot_type      rd_slot;
   scan_type      summary;
   logic [AW-1:0] match_idx;
   logic [AW-1:0] free_idx;
   logic [AW-1:0] top_idx;
   req_type       req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;
   logic          upd_we;
   logic [AW-1:0] upd_addr;
   slot_type      upd_slot;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   slot_type      ram_wdata;

   kmq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .ctl   (ctl),
      .addr  (addr)
   );

   kmq_slot_ram #(.DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctl.scan_rd),
      .raddr (addr),
      .rdata (rd_slot)
   );

   kmq_scan #(.DEPTH(DEPTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .addr      (addr),
      .rd_slot   (rd_slot),
      .key_id    (req_ff.task_id),
      .summary   (summary),
      .match_idx (match_idx),
      .free_idx  (free_idx),
      .top_idx   (top_idx)
   );

   // Hold the request beat for the whole pass.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff <= req_data;
      end
   end

   // Decide the outcome and the slot update from the pass summary.
   always_comb begin
      rsp_data_in.owner_out = '0;
      rsp_data_in.status    = ST_OK;
      upd_we                = 1'b0;
      upd_addr              = match_idx;
      upd_slot.used         = 1'b0;
      upd_slot.task_id      = req_ff.task_id;
      upd_slot.owner        = summary.found_owner;
      upd_slot.prio         = req_ff.priority_req;
      unique case (req_ff.op)
         OP_ADD: begin
            if (summary.found) begin
               rsp_data_in.status = ST_DUP;
            end else if (!summary.free_found) begin
               rsp_data_in.status = ST_FULL;
            end else begin
               upd_we         = 1'b1;
               upd_addr       = free_idx;
               upd_slot.used  = 1'b1;
               upd_slot.owner = req_ff.user_id;
            end
         end
         OP_EDIT: begin
            if (!summary.found) begin
               rsp_data_in.status = ST_NOTFOUND;
            end else begin
               upd_we        = 1'b1;
               upd_slot.used = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!summary.found) begin
               rsp_data_in.status = ST_NOTFOUND;
            end else begin
               upd_we = 1'b1;
            end
         end
         OP_EXEC: begin
            if (!summary.top_found) begin
               rsp_data_in.status = ST_EMPTY;
            end else begin
               upd_we                = 1'b1;
               upd_addr              = top_idx;
               rsp_data_in.owner_out = summary.top_owner;
            end
         end
         default: begin
            rsp_data_in.status = ST_OK;
         end
      endcase
   end

   // The clearing pass and the write-back share the memory's write port.
   always_comb begin
      if (ctl.clearing) begin
         ram_we    = 1'b1;
         ram_waddr = addr;
         ram_wdata = '0;
      end else begin
         ram_we    = ctl.commit && upd_we;
         ram_waddr = upd_addr;
         ram_wdata = upd_slot;
      end
   end

   // Result beat register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.commit;
      end
      if (ctl.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign busy      = ctl.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/kmq_slot_ram.sv
`default_nettype none

module kmq_slot_ram
   import kmq_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire slot_type      wdata,
   input  wire logic          re,
   input  wire logic [AW-1:0] raddr,
   output slot_type           rdata
);

   slot_type mem [DEPTH];
   slot_type rdata_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/kmq_scan.sv
`default_nettype none

module kmq_scan
   import kmq_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_type      ctl,
   input  wire logic [AW-1:0] addr,
   input  wire slot_type      rd_slot,
   input  wire logic [15:0]   key_id,
   output scan_type           summary,
   output logic [AW-1:0]      match_idx,
   output logic [AW-1:0]      free_idx,
   output logic [AW-1:0]      top_idx
);

   logic          rd_valid_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          found_ff;
   logic          free_found_ff;
   logic          top_found_ff;
   logic [15:0]   found_owner_ff;
   logic [15:0]   top_owner_ff;
   logic [31:0]   top_prio_ff;
   logic [15:0]   top_task_ff;
   logic [AW-1:0] match_idx_ff;
   logic [AW-1:0] free_idx_ff;
   logic [AW-1:0] top_idx_ff;
   logic          hit;
   logic          free_hit;
   logic          better;

   // The read data of a slot arrives in the cycle after its address.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.scan_rd;
      end
      rd_addr_ff <= addr;
   end

   // Compare the slot on the read port against the key and the best so far.
   always_comb begin
      hit      = rd_valid_ff && rd_slot.used && (rd_slot.task_id == key_id);
      free_hit = rd_valid_ff && !rd_slot.used && !free_found_ff;
      better   = rd_valid_ff && rd_slot.used &&
                 (!top_found_ff ||
                  ({rd_slot.prio, rd_slot.task_id} > {top_prio_ff, top_task_ff}));
   end

   // Accumulate the match, the lowest free slot and the top task.
   always_ff @(posedge clock) begin
      if (reset || ctl.accept) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         top_found_ff  <= 1'b0;
      end else begin
         if (hit) begin
            found_ff <= 1'b1;
         end
         if (free_hit) begin
            free_found_ff <= 1'b1;
         end
         if (better) begin
            top_found_ff <= 1'b1;
         end
      end
      if (hit) begin
         match_idx_ff   <= rd_addr_ff;
         found_owner_ff <= rd_slot.owner;
      end
      if (free_hit) begin
         free_idx_ff <= rd_addr_ff;
      end
      if (better) begin
         top_idx_ff   <= rd_addr_ff;
         top_prio_ff  <= rd_slot.prio;
         top_task_ff  <= rd_slot.task_id;
         top_owner_ff <= rd_slot.owner;
      end
   end

   always_comb begin
      summary.found       = found_ff;
      summary.found_owner = found_owner_ff;
      summary.free_found  = free_found_ff;
      summary.top_found   = top_found_ff;
      summary.top_owner   = top_owner_ff;
   end

   assign match_idx = match_idx_ff;
   assign free_idx  = free_idx_ff;
   assign top_idx   = top_idx_ff;

endmodule

`default_nettype wire

### src/kmq_ctrl.sv
`default_nettype none

module kmq_ctrl
   import kmq_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output ctrl_type        ctl,
   output logic [AW-1:0]   addr
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   state_type     state_ff;
   state_type     state_in;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] addr_in;
   logic          last;

   assign last = (addr_ff == LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Phase strobes.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_CLEAR: begin
            ctl.busy     = 1'b1;
            ctl.clearing = 1'b1;
         end
         S_IDLE: begin
            ctl.accept = start;
         end
         S_SCAN: begin
            ctl.busy    = 1'b1;
            ctl.scan_rd = 1'b1;
         end
         S_DRAIN: begin
            ctl.busy = 1'b1;
         end
         S_COMMIT: begin
            ctl.busy   = 1'b1;
            ctl.commit = 1'b1;
         end
         default: begin
            ctl.busy = 1'b1;
         end
      endcase
   end

   // The address walks the memory during the clearing pass and each scan.
   always_comb begin
      case (state_ff)
         S_CLEAR, S_SCAN: addr_in = addr_ff + 1'b1;
         default:         addr_in = '0;
      endcase
   end

   assign addr = addr_ff;

endmodule

`default_nettype wire

### src/kmq_checker.sv
`default_nettype none

module kmq_checker
   import kmq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted beat makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A result strobe lasts one cycle only.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result comes at the end of a busy period, when the block is free again.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result beat outside the end of a busy period");

   // Only a successful beat carries an owner.
   a_owner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.owner_out == 16'd0))
      else $error("owner reported with a failing status");

endmodule

bind keyed_max_priority_task_queue_core kmq_checker u_kmq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import kmq_pkg::*;

   localparam int Q_DEPTH      = 64;
   localparam int RANDOM_ITEMS = 1030;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PRINT_CAP    = 40;

   // Sender idle percentage per random phase; the first and third phases run
   // without idling. The receiver cannot hold results off.
   localparam int IDLE_PCT [4] = '{0, 46, 0, 26};

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_kind_type;

   // One row of the directed table. Where checked_here is set, the expected
   // beat is written in the row; otherwise it comes from the queue predictor.
   typedef struct {
      op_type      op;
      logic [15:0] user;
      logic [15:0] tid;
      logic [31:0] prio;
      bit          checked_here;
      logic [15:0] want_owner;
      status_type  want_status;
   } directed_row_type;

   localparam int DIR_COUNT = 19;

   directed_row_type directed_rows [DIR_COUNT] = '{
      // Nothing held yet: execute, edit and remove all miss.
      '{OP_EXEC,   16'hBEEF, 16'h1234, 32'h0000_0005, 1'b1, 16'h0000, ST_EMPTY},
      '{OP_EDIT,   16'h0000, 16'h1234, 32'h0000_0007, 1'b1, 16'h0000, ST_NOTFOUND},
      '{OP_REMOVE, 16'h0000, 16'h1234, 32'h0000_0000, 1'b1, 16'h0000, ST_NOTFOUND},
      // Extremes of every field, then a duplicate id.
      '{OP_ADD,    16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_OK},
      '{OP_ADD,    16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_OK},
      '{OP_ADD,    16'h1234, 16'hFFFF, 32'h0000_0001, 1'b1, 16'h0000, ST_DUP},
      // Equal top priority: the higher task id leaves first.
      '{OP_ADD,    16'h1111, 16'h0100, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_OK},
      '{OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'hFFFF, ST_OK},
      '{OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h1111, ST_OK},
      // Edit keeps the owner; user_id of the edit beat is ignored.
      '{OP_EDIT,   16'h7777, 16'h0000, 32'h8000_0000, 1'b1, 16'h0000, ST_OK},
      '{OP_ADD,    16'h0505, 16'h0005, 32'h8000_0000, 1'b1, 16'h0000, ST_OK},
      '{OP_EXEC,   16'hAAAA, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, 16'h0000, ST_OK},
      '{OP_EXEC,   16'h5555, 16'h5555, 32'h5555_5555, 1'b0, 16'h0000, ST_OK},
      '{OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_EMPTY},
      // Remove by id, then edit and remove of the id that is gone.
      '{OP_ADD,    16'hA5A5, 16'h5A5A, 32'h1234_5678, 1'b1, 16'h0000, ST_OK},
      '{OP_REMOVE, 16'hFFFF, 16'h5A5A, 32'hFFFF_FFFF, 1'b1, 16'h0000, ST_OK},
      '{OP_REMOVE, 16'h0000, 16'h5A5A, 32'h0000_0000, 1'b1, 16'h0000, ST_NOTFOUND},
      '{OP_EDIT,   16'h0000, 16'h5A5A, 32'h0000_0009, 1'b1, 16'h0000, ST_NOTFOUND},
      '{OP_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, ST_EMPTY}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_beat = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the slot memory.
   bit [31:0] tq_prio  [Q_DEPTH];
   bit [15:0] tq_task  [Q_DEPTH];
   bit [15:0] tq_owner [Q_DEPTH];
   bit        tq_used  [Q_DEPTH];
   int        tq_held;
   int        tq_peak;

   rsp_type pending_outcomes [$];
   int      error_count;
   int      beats_sent;
   int      results_checked;
   int      cycle_count;
   int      status_tally [5];

   keyed_max_priority_task_queue_core #(
      .DEPTH(Q_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_beat),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Applies one request to the shadow queue and returns the result it owes.
   function automatic rsp_type apply_queue_op(input req_type beat);
      rsp_type outcome;
      int      hit;
      int      free_slot;
      int      best;
      outcome.owner_out = '0;
      outcome.status    = ST_OK;
      hit       = -1;
      free_slot = -1;
      best      = -1;
      for (int i = 0; i < Q_DEPTH; i++) begin
         if (tq_used[i] && tq_task[i] == beat.task_id) begin
            hit = i;
         end
         if (!tq_used[i] && free_slot < 0) begin
            free_slot = i;
         end
         if (tq_used[i] && (best < 0 || tq_prio[i] > tq_prio[best] ||
               (tq_prio[i] == tq_prio[best] && tq_task[i] > tq_task[best]))) begin
            best = i;
         end
      end
      case (beat.op)
         OP_ADD: begin
            if (hit >= 0) begin
               outcome.status = ST_DUP;
            end else if (free_slot < 0) begin
               outcome.status = ST_FULL;
            end else begin
               tq_used[free_slot]  = 1'b1;
               tq_task[free_slot]  = beat.task_id;
               tq_owner[free_slot] = beat.user_id;
               tq_prio[free_slot]  = beat.priority_req;
               tq_held++;
               if (tq_held > tq_peak) begin
                  tq_peak = tq_held;
               end
            end
         end
         OP_EDIT: begin
            if (hit < 0) begin
               outcome.status = ST_NOTFOUND;
            end else begin
               tq_prio[hit] = beat.priority_req;
            end
         end
         OP_REMOVE: begin
            if (hit < 0) begin
               outcome.status = ST_NOTFOUND;
            end else begin
               tq_used[hit] = 1'b0;
               tq_held--;
            end
         end
         default: begin
            if (best < 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.owner_out = tq_owner[best];
               tq_used[best] = 1'b0;
               tq_held--;
            end
         end
      endcase
      return outcome;
   endfunction

   // Id of a randomly chosen held task, or a random id when the queue is empty.
   function automatic logic [15:0] pick_held_id();
      int k;
      if (tq_held == 0) begin
         return 16'($urandom_range(0, 65535));
      end
      k = $urandom_range(0, tq_held - 1);
      for (int i = 0; i < Q_DEPTH; i++) begin
         if (tq_used[i]) begin
            if (k == 0) begin
               return tq_task[i];
            end
            k--;
         end
      end
      return 16'h0000;
   endfunction

   // Offers one request beat, waits for its acceptance and records the
   // result it owes.
   task automatic send_beat(input req_type beat, input bit checked_here,
                            input rsp_type want, input int idle_pct);
      rsp_type forecast;
      // Now and then a long gap, so the next beat lands on any phase of a pass.
      if (idle_pct > 0 && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2 * Q_DEPTH)) @(posedge clock);
      end
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_beat <= beat;
      do @(posedge clock); while (busy !== 1'b0);
      forecast = apply_queue_op(beat);
      status_tally[int'(forecast.status)]++;
      beats_sent++;
      pending_outcomes.push_back(checked_here ? want : forecast);
   endtask

   // Every result beat is matched against the oldest owed result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            flag_error($sformatf("result beat owner %h status %0d with nothing owed",
                                 rsp_data.owner_out, rsp_data.status));
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (rsp_data.owner_out !== want.owner_out) begin
               flag_error($sformatf("result %0d owner_out %h, predicted %h",
                                    results_checked, rsp_data.owner_out, want.owner_out));
            end
            if (rsp_data.status !== want.status) begin
               flag_error($sformatf("result %0d status %0d, predicted %0d",
                                    results_checked, rsp_data.status, want.status));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_outcomes.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_type      beat;
      rsp_type      want;
      mix_kind_type mix;
      int           stretch_left;
      int           pct;
      int           roll;

      // Reset is held first, then released; the clearing pass shows up as busy.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, no idling.
      for (int r = 0; r < DIR_COUNT; r++) begin
         beat.op           = directed_rows[r].op;
         beat.user_id      = directed_rows[r].user;
         beat.task_id      = directed_rows[r].tid;
         beat.priority_req = directed_rows[r].prio;
         want.owner_out    = directed_rows[r].want_owner;
         want.status       = directed_rows[r].want_status;
         send_beat(beat, directed_rows[r].checked_here, want, 0);
      end

      // Random stretches that favour filling the queue or draining it,
      // or mix all operations evenly.
      stretch_left = 0;
      mix          = MIX_FILL;
      want         = '0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (stretch_left == 0) begin
            roll         = $urandom_range(0, 2);
            mix          = mix_kind_type'(roll);
            stretch_left = $urandom_range(20, 120);
         end
         stretch_left--;
         pct  = IDLE_PCT[n * 4 / RANDOM_ITEMS];
         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL:  beat.op = roll < 80 ? OP_ADD : roll < 88 ? OP_EDIT :
                                 roll < 94 ? OP_REMOVE : OP_EXEC;
            MIX_DRAIN: beat.op = roll < 10 ? OP_ADD : roll < 20 ? OP_EDIT :
                                 roll < 35 ? OP_REMOVE : OP_EXEC;
            default:   beat.op = op_type'(roll % 4);
         endcase
         beat.user_id = 16'($urandom_range(0, 65535));
         roll = $urandom_range(0, 99);
         if (beat.op == OP_ADD) begin
            // Mostly fresh ids, some duplicates, some from a narrow range.
            beat.task_id = roll < 70 ? 16'($urandom_range(0, 65535)) :
                           roll < 90 ? pick_held_id() : 16'($urandom_range(0, 15));
         end else begin
            beat.task_id = roll < 75 ? pick_held_id() : 16'($urandom_range(0, 65535));
         end
         roll = $urandom_range(0, 99);
         beat.priority_req = roll < 60 ? $urandom :
                             roll < 80 ? 32'($urandom_range(0, 3)) :
                             roll < 90 ? 32'h0000_0000 : 32'hFFFF_FFFF;
         send_beat(beat, 1'b0, want, pct);
      end
      start <= 1'b0;

      // Let every owed result arrive, then watch for strays.
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (Q_DEPTH + 8) @(posedge clock);

      $display("Sent %0d request beats (%0d from the table), checked %0d result beats.",
               beats_sent, DIR_COUNT, results_checked);
      $display("Outcomes ok %0d, empty %0d, not found %0d, full %0d, duplicate %0d; peak %0d of %0d.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4], tq_peak, Q_DEPTH);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
src/kmq_pkg.sv
src/kmq_slot_ram.sv
src/kmq_scan.sv
src/kmq_ctrl.sv
src/keyed_max_priority_task_queue_core.sv
src/kmq_checker.sv
dv/testbench.sv
